// File: hdl/hrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrl_pkg;

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_EOI  = 2'd2;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] REC_UPPER = 8'h04;

    localparam logic [9:0]  POS_MAX       = 10'd1023;
    localparam logic [31:0] NO_DATA_ENTRY = 32'h8000_0000;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] pos;
        logic [3:0] nib;
    } hrl_token_t;

endpackage

`default_nettype wire

// File: hdl/hrl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hrl_front
    import hrl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_byte,
    input  wire logic       end_of_input,
    output logic            tok_valid,
    input  wire logic       tok_ready,
    output hrl_token_t      tok
);

    logic [9:0] line_pos_reg;
    logic [9:0] line_pos_next;
    logic       skipped_reg;
    logic       skipped_next;
    logic       accept;
    logic [3:0] nib;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) n = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            n = c[3:0] + 4'd9;
        return n;
    endfunction

    assign in_ready = tok_ready;
    assign accept   = in_valid && tok_ready;
    assign nib      = nibble_of(char_byte);

    always_comb
    begin
        line_pos_next = line_pos_reg;
        skipped_next  = skipped_reg;
        tok_valid     = 1'b0;
        tok.op        = OP_CHAR;
        tok.pos       = skipped_reg ? 10'd0 : line_pos_reg;
        tok.nib       = nib;
        if (in_valid)
        begin
            if (end_of_input || char_byte == CHAR_NEWLINE)
            begin
                tok_valid     = 1'b1;
                tok.op        = end_of_input ? OP_EOI : OP_EOL;
                line_pos_next = 10'd0;
                skipped_next  = 1'b0;
            end
            else
            begin
                line_pos_next = (line_pos_reg < POS_MAX) ? line_pos_reg + 10'd1 : POS_MAX;
                if (!skipped_reg)
                begin
                    if (line_pos_reg == 10'd0)
                        skipped_next = (char_byte != CHAR_COLON);
                    else
                        tok_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg <= 10'd0;
            skipped_reg  <= 1'b0;
        end
        else if (accept)
        begin
            line_pos_reg <= line_pos_next;
            skipped_reg  <= skipped_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hrl_token_q.sv
`timescale 1ns / 1ps
`default_nettype none

module hrl_token_q
    import hrl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  hrl_token_t      push_tok,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output hrl_token_t      pop_tok
);

    hrl_token_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_tok    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hrl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hrl_back
    import hrl_pkg::*;
#(
    parameter longint unsigned MEM_BYTES = 64'd1048576
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tok_valid,
    output logic             tok_ready,
    input  hrl_token_t       tok,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [19:0]      write_offset,
    output logic [7:0]       write_byte,
    output logic [31:0]      entry_address,
    output logic [31:0]      load_base
);

    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

    logic [7:0]  rec_length_reg,  rec_length_next;
    logic [15:0] rec_address_reg, rec_address_next;
    logic [7:0]  rec_type_reg,    rec_type_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [15:0] upper_hi_reg,    upper_hi_next;
    logic [15:0] upper_accum_reg, upper_accum_next;
    logic [31:0] base_reg,        base_next;
    logic [31:0] offset_reg,      offset_next;
    logic        seen_reg,        seen_next;
    logic        finished_reg,    finished_next;
    logic        out_valid_reg,   out_valid_next;
    logic        kind_reg,        kind_next;
    logic [19:0] offset_out_reg,  offset_out_next;
    logic [7:0]  byte_out_reg,    byte_out_next;
    logic [31:0] entry_out_reg,   entry_out_next;
    logic [31:0] base_out_reg,    base_out_next;

    logic        take;
    logic        load_out;
    logic [9:0]  p;
    logic [8:0]  idx;
    logic [7:0]  data_byte;
    logic [31:0] full_now;
    logic [32:0] sum;
    logic [15:0] addr_fill;
    logic [7:0]  type_fill;

    assign take      = tok_valid && (!out_valid_reg || out_ready);
    assign tok_ready = take;
    assign p         = tok.pos;
    assign idx       = p[9:1] - 9'd5;
    assign data_byte = {high_nibble_reg, tok.nib};
    assign full_now  = {upper_hi_reg, rec_address_reg};
    assign sum       = {1'b0, offset_reg} + {24'd0, idx};

    always_comb
    begin
        case (p)
            10'd1, 10'd2, 10'd3: addr_fill = 16'd0;
            10'd4:               addr_fill = {rec_address_reg[3:0], 12'd0};
            10'd5:               addr_fill = {rec_address_reg[7:0], 8'd0};
            10'd6:               addr_fill = {rec_address_reg[11:0], 4'd0};
            default:             addr_fill = rec_address_reg;
        endcase
        type_fill = (p == 10'd8) ? {high_nibble_reg, 4'd0} : 8'd0;
    end

    always_comb
    begin
        rec_length_next  = rec_length_reg;
        rec_address_next = rec_address_reg;
        rec_type_next    = rec_type_reg;
        high_nibble_next = high_nibble_reg;
        upper_hi_next    = upper_hi_reg;
        upper_accum_next = upper_accum_reg;
        base_next        = base_reg;
        offset_next      = offset_reg;
        seen_next        = seen_reg;
        finished_next    = finished_reg;
        load_out         = 1'b0;
        kind_next        = 1'b0;
        offset_out_next  = 20'd0;
        byte_out_next    = 8'd0;
        entry_out_next   = 32'd0;
        base_out_next    = 32'd0;

        if (take && !finished_reg)
        begin
            case (tok.op)
                OP_CHAR:
                begin
                    if (p == 10'd1 || p == 10'd7)
                        high_nibble_next = tok.nib;
                    else if (p == 10'd2)
                        rec_length_next = data_byte;
                    else if (p >= 10'd3 && p <= 10'd6)
                        rec_address_next = {rec_address_reg[11:0], tok.nib};
                    else if (p == 10'd8)
                    begin
                        rec_type_next = data_byte;
                        if (data_byte == REC_DATA)
                        begin
                            if (!seen_reg)
                            begin
                                base_next   = full_now;
                                seen_next   = 1'b1;
                                offset_next = 32'd0;
                            end
                            else
                                offset_next = full_now - base_reg;
                        end
                        else if (data_byte == REC_UPPER)
                            upper_accum_next = 16'd0;
                        else if (data_byte == REC_EOF)
                        begin
                            load_out       = 1'b1;
                            kind_next      = 1'b1;
                            entry_out_next = base_reg;
                            base_out_next  = base_reg;
                            finished_next  = 1'b1;
                        end
                    end
                    else if (p[0])
                        high_nibble_next = tok.nib;
                    else if (idx < {1'b0, rec_length_reg})
                    begin
                        if (rec_type_reg == REC_UPPER)
                            upper_accum_next = {upper_accum_reg[7:0], data_byte};
                        else if (rec_type_reg == REC_DATA && sum < MEM_LIMIT)
                        begin
                            load_out        = 1'b1;
                            offset_out_next = sum[19:0];
                            byte_out_next   = data_byte;
                        end
                    end
                end
                OP_EOL, OP_EOI:
                begin
                    if (p != 10'd0)
                    begin
                        if (p <= 10'd8)
                        begin
                            rec_address_next = addr_fill;
                            rec_type_next    = type_fill;
                            if (type_fill == REC_DATA && !seen_reg)
                            begin
                                base_next = {upper_hi_reg, addr_fill};
                                seen_next = 1'b1;
                            end
                        end
                        else if (rec_type_reg == REC_UPPER)
                            upper_hi_next = upper_accum_reg;
                    end
                    if (tok.op == OP_EOI)
                    begin
                        load_out       = 1'b1;
                        kind_next      = 1'b1;
                        entry_out_next = base_next;
                        base_out_next  = base_next;
                        finished_next  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_length_reg  <= 8'd0;
            rec_address_reg <= 16'd0;
            rec_type_reg    <= 8'd0;
            high_nibble_reg <= 4'd0;
            upper_hi_reg    <= 16'd0;
            upper_accum_reg <= 16'd0;
            base_reg        <= NO_DATA_ENTRY;
            offset_reg      <= 32'd0;
            seen_reg        <= 1'b0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rec_length_reg  <= rec_length_next;
            rec_address_reg <= rec_address_next;
            rec_type_reg    <= rec_type_next;
            high_nibble_reg <= high_nibble_next;
            upper_hi_reg    <= upper_hi_next;
            upper_accum_reg <= upper_accum_next;
            base_reg        <= base_next;
            offset_reg      <= offset_next;
            seen_reg        <= seen_next;
            finished_reg    <= finished_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg       <= kind_next;
            offset_out_reg <= offset_out_next;
            byte_out_reg   <= byte_out_next;
            entry_out_reg  <= entry_out_next;
            base_out_reg   <= base_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign write_offset  = offset_out_reg;
    assign write_byte    = byte_out_reg;
    assign entry_address = entry_out_reg;
    assign load_base     = base_out_reg;

    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag dropped");

    a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && !out_valid_reg |=> !out_valid_reg)
        else $error("beat produced after summary");

    a_summary_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg |-> finished_reg)
        else $error("summary beat without finished flag");

    a_write_after_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !kind_reg |-> seen_reg)
        else $error("byte write before any data record");

endmodule

`default_nettype wire

// File: hdl/hex_record_loader_core.sv
// Hex record loader core.
// Input channel (in_valid/in_ready): one beat per character of hex-record
// text in char_byte; a beat with end_of_input high closes the text and its
// character is ignored.
// Output channel (out_valid/out_ready): kind 0 beats are memory byte writes
// (write_offset, write_byte); one kind 1 beat closes loading and carries
// entry_address and load_base. After it all input is taken and dropped.
// A front stage tracks line position and decodes nibbles, a two-entry token
// queue decouples it from the back stage, which parses the record header
// and drives a registered output slot.
// Throughput: one character per cycle while the receiver keeps up.
// A result passes through the token queue and the registered output slot.
// When the receiver stalls, the output slot holds, the back stage stops,
// the queue fills and in_ready drops once it holds two tokens.
// Reset clears control state but not the output data or queue storage;
// the block takes characters from the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module hex_record_loader_core
    import hrl_pkg::*;
#(
    parameter longint unsigned MEM_BYTES = 64'd1048576
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_byte,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [19:0]      write_offset,
    output logic [7:0]       write_byte,
    output logic [31:0]      entry_address,
    output logic [31:0]      load_base
);

    hrl_token_t front_tok;
    hrl_token_t back_tok;
    logic       front_valid;
    logic       front_ready;
    logic       back_valid;
    logic       back_ready;

    hrl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_byte    (char_byte),
        .end_of_input (end_of_input),
        .tok_valid    (front_valid),
        .tok_ready    (front_ready),
        .tok          (front_tok)
    );

    hrl_token_q u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_tok    (back_tok)
    );

    hrl_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (back_valid),
        .tok_ready     (back_ready),
        .tok           (back_tok),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .write_offset  (write_offset),
        .write_byte    (write_byte),
        .entry_address (entry_address),
        .load_base     (load_base)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb
    import hrl_pkg::*;
;

    localparam longint unsigned MEM_SIZE = 64'd1048576;
    localparam logic [15:0] BASE_UPPER = 16'hABCD;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] OTHER_TYPES [8] =
        '{8'h02, 8'h03, 8'h05, 8'h0A, 8'h10, 8'hFF, 8'h40, 8'hE2};

    typedef struct packed {
        logic        kind;
        logic [19:0] offset;
        logic [7:0]  data;
        logic [31:0] entry;
        logic [31:0] base;
    } load_beat_t;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_RARE} ready_mode_t;

    class hex_load_board;
        logic [9:0]  line_pos;
        bit          line_skipped;
        logic [7:0]  rec_length;
        logic [7:0]  rec_type;
        logic [15:0] rec_address;
        logic [3:0]  high_nib;
        logic [31:0] upper_address;
        logic [31:0] upper_accum;
        logic [31:0] base_address;
        logic [31:0] first_address;
        bit          seen_data;
        bit          finished;
        load_beat_t  loads_due[$];
        int          errors;

        function new();
            line_pos      = '0;
            line_skipped  = 1'b0;
            rec_length    = '0;
            rec_type      = '0;
            rec_address   = '0;
            high_nib      = '0;
            upper_address = '0;
            upper_accum   = '0;
            base_address  = NO_DATA_ENTRY;
            first_address = '0;
            seen_data     = 1'b0;
            finished      = 1'b0;
            errors        = 0;
        endfunction

        function logic [3:0] hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return 4'(c - "0");
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            return 4'd0;
        endfunction

        function void post_summary();
            loads_due.push_back('{1'b1, 20'd0, 8'd0,
                seen_data ? first_address : NO_DATA_ENTRY, base_address});
            finished = 1'b1;
        endfunction

        function bit parse_header(logic [9:0] p, logic [3:0] n);
            logic [31:0] full;
            if (p == 1 || p == 7) begin
                high_nib = n;
            end
            else if (p == 2) begin
                rec_length = {high_nib, n};
            end
            else if (p >= 3 && p <= 6) begin
                rec_address = {rec_address[11:0], n};
            end
            else if (p == 8) begin
                rec_type = {high_nib, n};
                if (rec_type == REC_DATA) begin
                    full = {16'd0, rec_address} + upper_address;
                    if (!seen_data) begin
                        base_address  = full;
                        first_address = full;
                        seen_data     = 1'b1;
                    end
                end
                else if (rec_type == REC_UPPER) begin
                    upper_accum = '0;
                end
                else if (rec_type == REC_EOF) begin
                    post_summary();
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit close_line();
            bit got;
            got = 1'b0;
            if (line_pos != 0 && !line_skipped) begin
                for (int p = line_pos; p <= 8 && !got; p++)
                    got = parse_header(10'(p), 4'd0);
                if (!got && rec_type == REC_UPPER)
                    upper_address = upper_accum << 16;
            end
            line_pos     = '0;
            line_skipped = 1'b0;
            return got;
        endfunction

        function void note_char(logic [7:0] c, logic eoi);
            logic [9:0]      p;
            logic [3:0]      n;
            logic [7:0]      data;
            logic [31:0]     offset;
            int unsigned     idx;
            longint unsigned spot;
            if (finished) return;
            if (eoi) begin
                if (!close_line()) post_summary();
                return;
            end
            if (c == CHAR_NEWLINE) begin
                void'(close_line());
                return;
            end
            p = line_pos;
            line_pos = (p < POS_MAX) ? p + 10'd1 : POS_MAX;
            if (line_skipped) return;
            if (p == 0) begin
                if (c != CHAR_COLON) line_skipped = 1'b1;
                return;
            end
            n = hex_value(c);
            if (p <= 8) begin
                void'(parse_header(p, n));
                return;
            end
            if (p[0]) begin
                high_nib = n;
                return;
            end
            idx = (p - 10) >> 1;
            if (idx >= rec_length) return;
            data = {high_nib, n};
            if (rec_type == REC_UPPER) begin
                upper_accum = {upper_accum[23:0], data};
                return;
            end
            if (rec_type != REC_DATA) return;
            offset = {16'd0, rec_address} + upper_address - base_address;
            spot = 64'(offset) + 64'(idx);
            if (spot >= MEM_SIZE) return;
            loads_due.push_back('{1'b0, spot[19:0], data, 32'd0, 32'd0});
        endfunction

        function void check_result(load_beat_t got);
            load_beat_t want;
            if (loads_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: kind %0d off %h byte %h entry %h base %h",
                             got.kind, got.offset, got.data, got.entry, got.base);
                return;
            end
            want = loads_due.pop_front();
            if (got.kind !== want.kind || got.offset !== want.offset ||
                got.data !== want.data || got.entry !== want.entry ||
                got.base !== want.base) begin
                errors++;
                if (errors <= 10) begin
                    $display("beat mismatch: want kind %0d off %h byte %h entry %h base %h",
                             want.kind, want.offset, want.data, want.entry, want.base);
                    $display("                got kind %0d off %h byte %h entry %h base %h",
                             got.kind, got.offset, got.data, got.entry, got.base);
                end
            end
        endfunction

        function void close_out();
            if (loads_due.size() != 0) begin
                errors += loads_due.size();
                if (errors <= 10)
                    $display("%0d beats never arrived", loads_due.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  char_byte    = 8'd0;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        kind;
    logic [19:0] write_offset;
    logic [7:0]  write_byte;
    logic [31:0] entry_address;
    logic [31:0] load_base;

    hex_load_board board = new();
    load_beat_t    got_beat;
    ready_mode_t   ready_mode = RDY_ALWAYS;
    int            mode_left = 0;
    int            ready_tick = 0;
    int            burst_left = 0;
    int            record_chars = 0;

    hex_record_loader_core #(
        .MEM_BYTES(MEM_SIZE)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .char_byte(char_byte),
        .end_of_input(end_of_input),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .write_offset(write_offset),
        .write_byte(write_byte),
        .entry_address(entry_address),
        .load_base(load_base)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            got_beat = '{kind, write_offset, write_byte, entry_address, load_base};
            board.check_result(got_beat);
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        ready_tick++;
        case (ready_mode)
            RDY_ALWAYS: out_ready <= 1'b1;
            RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:    out_ready <= (ready_tick % 12 == 0);
        endcase
    end

    function automatic string hex_text(logic [31:0] v, int digits);
        string      s;
        logic [3:0] d;
        logic [7:0] ch;
        s = "";
        for (int k = digits - 1; k >= 0; k--) begin
            d = v[4*k +: 4];
            if (d < 10)
                ch = CH_ZERO + d;
            else
                ch = ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + d - 8'd10;
            s = $sformatf("%s%c", s, ch);
        end
        return s;
    endfunction

    task automatic send_beat(input logic [7:0] c, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        char_byte    <= c;
        end_of_input <= eoi;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        board.note_char(c, eoi);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_beat(s[k], 1'b0);
    endtask

    // hold the sender until every pending beat has drained
    task automatic drain_loads();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.loads_due.size() != 0);
    endtask

    task automatic send_noise();
        logic [7:0] c;
        int         n;
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_COLON || c == CHAR_NEWLINE) c = 8'h00;
        send_beat(c, 1'b0);
        n = $urandom_range(0, 12);
        repeat (n) begin
            c = 8'($urandom());
            if (c == CHAR_NEWLINE) c = CHAR_COLON;
            send_beat(c, 1'b0);
        end
        send_beat(CHAR_NEWLINE, 1'b0);
    endtask

    task automatic send_record(input logic [7:0] rtype, input logic [7:0] len,
                               input logic [15:0] addr, input logic [31:0] word,
                               input bit mangle, input int tail);
        string      line;
        logic [7:0] data;
        int         cut;
        line = {":", hex_text(len, 2), hex_text(addr, 4), hex_text(rtype, 2)};
        for (int k = 0; k < len; k++) begin
            if (rtype == REC_UPPER && len <= 4)
                data = word[8*(len-1-k) +: 8];
            else
                data = 8'($urandom());
            line = {line, hex_text(data, 2)};
        end
        line = {line, hex_text($urandom(), 2)};
        for (int k = 0; k < tail; k++)
            line = $sformatf("%s%c", line, 8'($urandom_range(33, 126)));
        if (mangle) begin
            case ($urandom_range(0, 15))
                0: line = line.substr(0, $urandom_range(0, line.len() - 2));
                1:
                begin
                    cut = (line.len() > 9) ? $urandom_range(9, line.len() - 1)
                                           : $urandom_range(3, 6);
                    line[cut] = 8'($urandom_range(1, 255));
                end
                2: line = {line, hex_text($urandom(), 3)};
                3: line = $sformatf("%s%c", line, CH_CR);
                default: ;
            endcase
        end
        if (tail == 0) record_chars += line.len() + 1;
        send_text({line, "\n"});
    endtask

    initial
    begin
        string       line;
        logic [7:0]  len;
        logic [31:0] word;
        int          pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("skip this line\n");
        send_text(":02000004ABCD\n");
        send_text(":0310000011ff7G\n");
        send_text(":01FFFF00EE\n");
        send_text(":0100000055\n");
        send_text(":0210040012");
        send_beat(CH_CR, 1'b0);
        send_text("3\n");
        send_text(":0100000277\n");
        send_text(":0\n");
        send_text("\n");
        send_text(":02000004\n");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CHAR_NEWLINE, 1'b0);
        drain_loads();

        send_record(REC_UPPER, 8'd2, 16'd0, {16'd0, BASE_UPPER}, 1'b0, 0);
        while (record_chars < 320) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_noise();
            end
            else if (pick < 11) begin
                send_beat(CHAR_NEWLINE, 1'b0);
            end
            else if (pick < 23) begin
                len  = ($urandom_range(0, 9) < 8) ? 8'd2 : 8'($urandom_range(0, 4));
                word = ($urandom_range(0, 4) != 0) ? BASE_UPPER + $urandom_range(0, 17)
                                                   : $urandom();
                send_record(REC_UPPER, len, 16'($urandom()), word, 1'b1, 0);
            end
            else if (pick < 29) begin
                send_record(OTHER_TYPES[$urandom_range(0, 7)], 8'($urandom_range(0, 8)),
                            16'($urandom()), $urandom(), 1'b1, 0);
            end
            else begin
                len = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 16))
                                                  : 8'($urandom_range(17, 40));
                send_record(REC_DATA, len, 16'($urandom()), $urandom(), 1'b1, 0);
            end
            if ($urandom_range(0, 39) == 0) drain_loads();
        end

        // long record with trailing characters past its data bytes
        send_record(REC_UPPER, 8'd2, 16'd0, {16'd0, BASE_UPPER}, 1'b0, 0);
        send_record(REC_DATA, 8'h50, 16'($urandom_range(16'h1000, 16'hFFFF)), 32'd0,
                    1'b0, 24);

        if ($urandom_range(0, 1)) begin
            send_text(":00000001FF\n");
        end
        else begin
            line = {":", hex_text($urandom_range(0, 6), 2), hex_text($urandom(), 4), "00",
                    hex_text($urandom(), 8), hex_text($urandom(), 4)};
            line = line.substr(0, $urandom_range(0, line.len() - 1));
            send_text(line);
            send_beat(8'($urandom()), 1'b1);
        end
        for (int k = 0; k < 6; k++)
            send_beat(8'($urandom()), 1'($urandom_range(0, 1)));

        in_valid <= 1'b0;
        do @(posedge clk); while (board.loads_due.size() != 0);
        repeat (8) @(posedge clk);
        board.close_out();
        if (board.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #500000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// File: hex_record_loader_core.f
hdl/hrl_pkg.sv
hdl/hrl_front.sv
hdl/hrl_token_q.sv
hdl/hrl_back.sv
hdl/hex_record_loader_core.sv
verif/tb.sv
